// ===== src/phl_pkg.sv =====
// Package for the positional handle list: word types, status and mode codes,
// and the control struct that steers each storage cell.
// Used by phl_cell and positional_handle_list_unit; depends on nothing else.
package phl_pkg;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic       mode;
        logic [5:0] position;
        logic [7:0] node_handle;
    } phl_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] removed_handle;
        logic [5:0] entry_count;
    } phl_out_t;

    // What a cell loads on the next edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LEFT,
        CELL_RIGHT,
        CELL_NEW
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     rd_sel;
    } cell_ctrl_t;

endpackage

// ===== src/phl_cell.sv =====
// One storage cell of the handle list: holds one entry and loads it from a
// neighbor, from the new handle, or keeps it. Depends on phl_pkg.
module phl_cell #(
    parameter int HANDLE_BITS = 8
) (
    input  logic                   clk,
    input  phl_pkg::cell_ctrl_t    ctrl,
    input  logic [HANDLE_BITS-1:0] left_val,
    input  logic [HANDLE_BITS-1:0] right_val,
    input  logic [HANDLE_BITS-1:0] new_val,
    output logic [HANDLE_BITS-1:0] val,
    output logic [HANDLE_BITS-1:0] tap
);
    import phl_pkg::*;

    logic [HANDLE_BITS-1:0] val_reg;
    logic [HANDLE_BITS-1:0] val_next;

    always_comb
    begin
        unique case (ctrl.op)
            CELL_LEFT:  val_next = left_val;
            CELL_RIGHT: val_next = right_val;
            CELL_NEW:   val_next = new_val;
            default:    val_next = val_reg;
        endcase
    end

    // Entries carry no reset: only cells below the count are ever read.
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign tap = ctrl.rd_sel ? val_reg : '0;

endmodule

// ===== src/positional_handle_list_unit.sv =====
// Top level of the positional handle list: a row of phl_cell instances that
// shift together, a count register and the registered result word.
// Depends on phl_pkg and phl_cell.
//
//  channel | ports                  | handshake
//  --------+------------------------+--------------------------------------
//  command | start, busy, in_word   | word taken when start && !busy
//  result  | done, out_word         | one-cycle strobe, cannot be stalled
//
// All cells shift in the same edge, so a new command may be issued on every
// cycle and busy stays low. The result word appears with done in the cycle
// after the command is taken. Reset clears the count and the done strobe;
// the stored handles are left as they are.
module positional_handle_list_unit #(
    parameter int DEPTH       = 32,
    parameter int HANDLE_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  phl_pkg::phl_in_t  in_word,
    output logic              done,
    output phl_pkg::phl_out_t out_word
);
    import phl_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             done_next;
    phl_out_t         out_reg;
    phl_out_t         out_next;

    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       cnt_ext;
    logic [HANDLE_BITS-1:0] new_handle;
    logic                   take;
    logic                   ins_ok;
    logic                   rem_ok;
    logic [1:0]             status;
    logic [HANDLE_BITS-1:0] removed;

    logic [HANDLE_BITS-1:0] cell_val [DEPTH];
    logic [HANDLE_BITS-1:0] cell_tap [DEPTH];
    cell_ctrl_t             cell_ctrl [DEPTH];

    assign take       = start && !busy;
    assign pos_ext    = CMP_W'(in_word.position);
    assign cnt_ext    = CMP_W'(count_reg);
    assign new_handle = HANDLE_BITS'(in_word.node_handle);

    always_comb
    begin
        ins_ok = 1'b0;
        rem_ok = 1'b0;
        status = ST_DONE;
        if (in_word.mode == MODE_INSERT)
        begin
            priority if (pos_ext > cnt_ext)
                status = ST_BAD_INDEX;
            else if (count_reg == CNT_W'(DEPTH))
                status = ST_FULL;
            else
                ins_ok = take;
        end
        else
        begin
            if (pos_ext >= cnt_ext)
                status = ST_BAD_INDEX;
            else
                rem_ok = take;
        end
    end

    // Per-cell steering: an insert opens a gap at the position, a remove
    // closes the gap by pulling later entries forward.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [CMP_W-1:0] idx;
        assign idx = CMP_W'(i);

        always_comb
        begin
            cell_ctrl[i].op     = CELL_HOLD;
            cell_ctrl[i].rd_sel = rem_ok && (idx == pos_ext);
            if (ins_ok)
            begin
                if (idx > pos_ext)
                    cell_ctrl[i].op = CELL_LEFT;
                else if (idx == pos_ext)
                    cell_ctrl[i].op = CELL_NEW;
            end
            else if (rem_ok && (idx >= pos_ext))
            begin
                cell_ctrl[i].op = CELL_RIGHT;
            end
        end

        phl_cell #(
            .HANDLE_BITS(HANDLE_BITS)
        ) u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl[i]),
            .left_val ((i == 0) ? new_handle : cell_val[(i == 0) ? 0 : i - 1]),
            .right_val((i == DEPTH - 1) ? cell_val[i]
                                        : cell_val[(i == DEPTH - 1) ? i : i + 1]),
            .new_val  (new_handle),
            .val      (cell_val[i]),
            .tap      (cell_tap[i])
        );
    end

    // At most one cell drives its tap, so the removed handle is their OR.
    always_comb
    begin
        removed = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            removed = removed | cell_tap[k];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
            count_next = count_reg + CNT_W'(1);
        else if (rem_ok)
            count_next = count_reg - CNT_W'(1);
    end

    always_comb
    begin
        done_next               = take;
        out_next.status         = status;
        out_next.removed_handle = 8'(removed);
        out_next.entry_count    = 6'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= out_next;
    end

    assign busy     = 1'b0;
    assign done     = done_reg;
    assign out_word = out_reg;

endmodule
